// ===== rtl/lzbd_pkg.sv =====
package lzbd_pkg;

  // Stream format
  localparam int DICT_BITS  = 13;
  localparam int MATCH_BITS = 4;
  localparam int CHAR_BITS  = 8;

  // Length floor register
  localparam int FLOOR_W     = 4;
  localparam int FLOOR_MAX   = 8;
  localparam int FLOOR_RESET = 2;

  // Token sizes in bits
  localparam int LIT_BITS   = 1 + CHAR_BITS;
  localparam int END_BITS   = 1 + MATCH_BITS;
  localparam int MATCH_TOK  = 1 + MATCH_BITS + DICT_BITS;

  // Pending bits never exceed an incomplete match plus one new byte
  localparam int ACC_W = MATCH_BITS + DICT_BITS + CHAR_BITS;
  localparam int CNT_W = $clog2(ACC_W + 1);

  // Longest match: largest non-end code plus the largest floor plus one
  localparam int LEN_MAX = (1 << MATCH_BITS) - 2 + FLOOR_MAX + 1;
  localparam int LEN_W   = $clog2(LEN_MAX + 1);

  // Emitting tokens that can sit in the pending bits at once, plus an end token
  localparam int SCAN_STEPS = ACC_W / LIT_BITS + 1;

  localparam int WIN_DEPTH = 1 << DICT_BITS;

  typedef logic [ACC_W-1:0]      acc_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [DICT_BITS-1:0]  pos_t;
  typedef logic [MATCH_BITS-1:0] code_t;
  typedef logic [CHAR_BITS-1:0]  char_t;
  typedef logic [FLOOR_W-1:0]    floor_t;

  localparam code_t END_CODE = '1;

  // True when the next token in the pending bits is complete and yields bytes
  function automatic logic token_emits(acc_t acc, cnt_t cnt);
    logic res;
    res = 1'b0;
    if (acc[0] == 1'b0) begin
      res = (cnt >= cnt_t'(LIT_BITS));
    end else begin
      res = (cnt >= cnt_t'(MATCH_TOK)) && (acc[MATCH_BITS:1] != END_CODE);
    end
    return res;
  endfunction

  // Walk the complete tokens in the pending bits and report an end token
  function automatic logic scan_end(acc_t acc, cnt_t cnt);
    acc_t a;
    cnt_t c;
    logic stop;
    logic found;
    a     = acc;
    c     = cnt;
    stop  = 1'b0;
    found = 1'b0;
    for (int i = 0; i < SCAN_STEPS; i++) begin
      if (!stop) begin
        if (c == '0) begin
          stop = 1'b1;
        end else if (a[0] == 1'b0) begin
          if (c < cnt_t'(LIT_BITS)) begin
            stop = 1'b1;
          end else begin
            a = a >> LIT_BITS;
            c = c - cnt_t'(LIT_BITS);
          end
        end else if (c < cnt_t'(END_BITS)) begin
          stop = 1'b1;
        end else if (a[MATCH_BITS:1] == END_CODE) begin
          found = 1'b1;
          stop  = 1'b1;
        end else if (c < cnt_t'(MATCH_TOK)) begin
          stop = 1'b1;
        end else begin
          a = a >> MATCH_TOK;
          c = c - cnt_t'(MATCH_TOK);
        end
      end
    end
    return found;
  endfunction

endpackage

// ===== rtl/lz77_bitstream_decoder.sv =====
// Channel  | Dir | Handshake                 | Payload
// ---------+-----+---------------------------+------------------------------------
// in_      | in  | in_tvalid / in_tready     | in_tdata: in_byte
// out_     | out | out_tvalid / out_tready   | out_tdata: out_byte, tlast, tuser
// cfg_     | in  | cfg_valid / cfg_ready     | cfg_data: length_floor
//
// A compressed byte is taken while idle. Each literal is emitted from the parse state, an end
// token is consumed there, and a match is decoded there and then copied byte by byte (history
// read, then write and output); a last parse step finds no complete token and returns to idle.
// Reset is synchronous; the history needs no clearing pass: entries not written
// since reset read as zero, tracked by the write pointer and a wrap flag.
// A stalled output register holds the decoder; input is taken only between bytes.
module lz77_bitstream_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lzbd_pkg::CHAR_BITS-1:0]  in_tdata,   // [7:0] in_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lzbd_pkg::CHAR_BITS-1:0]  out_tdata,  // [7:0] out_byte
  output logic                            out_tlast,  // last
  output logic                            out_tuser,  // [0] end_seen
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lzbd_pkg::FLOOR_W-1:0]    cfg_data    // [3:0] length_floor
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PARSE = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_COPY  = 2'd3;

  logic [1:0]              state_r, state_nxt;
  lzbd_pkg::acc_t          acc_r, acc_nxt;
  lzbd_pkg::cnt_t          count_r, count_nxt;
  lzbd_pkg::pos_t          wp_r, wp_nxt;
  logic                    wrapped_r, wrapped_nxt;
  logic                    done_r, done_nxt;
  logic                    step_end_r, step_end_nxt;
  lzbd_pkg::floor_t        floor_r;
  lzbd_pkg::pos_t          src_r, src_nxt;
  lzbd_pkg::len_t          len_r, len_nxt;
  logic                    src_valid_r, src_valid_nxt;
  logic                    out_valid_r, out_valid_nxt;
  lzbd_pkg::char_t         out_byte_r, out_byte_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_end_r, out_end_nxt;

  logic                    slot_free;
  logic                    in_fire;
  logic                    emit;
  lzbd_pkg::char_t         emit_byte;
  logic                    ram_re;
  lzbd_pkg::char_t         ram_rdata;
  lzbd_pkg::acc_t          acc_in;
  lzbd_pkg::cnt_t          count_in;
  lzbd_pkg::acc_t          acc_lit_rest, acc_match_rest;
  lzbd_pkg::cnt_t          count_lit_rest, count_match_rest;
  lzbd_pkg::code_t         tok_code;
  lzbd_pkg::pos_t          tok_dist;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_end_r;

  // Append the new byte above the pending bits
  assign acc_in   = acc_r | (lzbd_pkg::acc_t'(in_tdata) << count_r);
  assign count_in = count_r + lzbd_pkg::cnt_t'(lzbd_pkg::CHAR_BITS);

  // Token fields and what remains after each token kind
  assign tok_code         = acc_r[lzbd_pkg::MATCH_BITS:1];
  assign tok_dist         = acc_r[lzbd_pkg::MATCH_BITS+lzbd_pkg::DICT_BITS:
                                  lzbd_pkg::MATCH_BITS+1];
  assign acc_lit_rest     = acc_r >> lzbd_pkg::LIT_BITS;
  assign count_lit_rest   = count_r - lzbd_pkg::cnt_t'(lzbd_pkg::LIT_BITS);
  assign acc_match_rest   = acc_r >> lzbd_pkg::MATCH_TOK;
  assign count_match_rest = count_r - lzbd_pkg::cnt_t'(lzbd_pkg::MATCH_TOK);

  // History memory
  lzbd_ram #(
    .WIDTH (lzbd_pkg::CHAR_BITS),
    .DEPTH (lzbd_pkg::WIN_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (emit),
    .waddr (wp_r),
    .wdata (emit_byte),
    .re    (ram_re),
    .raddr (src_r),
    .rdata (ram_rdata)
  );

  // Decode sequencer
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    count_nxt     = count_r;
    wp_nxt        = wp_r;
    wrapped_nxt   = wrapped_r;
    done_nxt      = done_r;
    step_end_nxt  = step_end_r;
    src_nxt       = src_r;
    len_nxt       = len_r;
    src_valid_nxt = src_valid_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_end_nxt   = out_end_r;
    emit          = 1'b0;
    emit_byte     = acc_r[lzbd_pkg::CHAR_BITS:1];
    ram_re        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        // Take a byte; drop it once the stream has ended
        if (in_fire && !done_r) begin
          acc_nxt      = acc_in;
          count_nxt    = count_in;
          step_end_nxt = lzbd_pkg::scan_end(acc_in, count_in);
          state_nxt    = ST_PARSE;
        end
      end
      ST_PARSE: begin
        if (count_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (acc_r[0] == 1'b0) begin
          if (count_r < lzbd_pkg::cnt_t'(lzbd_pkg::LIT_BITS)) begin
            state_nxt = ST_IDLE;
          end else if (slot_free) begin
            emit         = 1'b1;
            emit_byte    = acc_r[lzbd_pkg::CHAR_BITS:1];
            out_last_nxt = !lzbd_pkg::token_emits(acc_lit_rest, count_lit_rest);
            acc_nxt      = acc_lit_rest;
            count_nxt    = count_lit_rest;
          end
        end else if (count_r < lzbd_pkg::cnt_t'(lzbd_pkg::END_BITS)) begin
          state_nxt = ST_IDLE;
        end else if (tok_code == lzbd_pkg::END_CODE) begin
          done_nxt  = 1'b1;
          acc_nxt   = '0;
          count_nxt = '0;
          state_nxt = ST_IDLE;
        end else if (count_r < lzbd_pkg::cnt_t'(lzbd_pkg::MATCH_TOK)) begin
          state_nxt = ST_IDLE;
        end else begin
          src_nxt   = wp_r - tok_dist;
          len_nxt   = lzbd_pkg::len_t'(tok_code) + lzbd_pkg::len_t'(floor_r)
                      + lzbd_pkg::len_t'(1);
          acc_nxt   = acc_match_rest;
          count_nxt = count_match_rest;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        // Entries never written since reset read as zero
        ram_re        = 1'b1;
        src_valid_nxt = wrapped_r || (src_r < wp_r);
        state_nxt     = ST_COPY;
      end
      ST_COPY: begin
        if (slot_free) begin
          emit         = 1'b1;
          emit_byte    = src_valid_r ? ram_rdata : '0;
          out_last_nxt = (len_r == lzbd_pkg::len_t'(1)) &&
                         !lzbd_pkg::token_emits(acc_r, count_r);
          src_nxt      = src_r + lzbd_pkg::pos_t'(1);
          len_nxt      = len_r - lzbd_pkg::len_t'(1);
          state_nxt    = (len_r == lzbd_pkg::len_t'(1)) ? ST_PARSE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Store the byte in the history and load the output register
    if (emit) begin
      wp_nxt        = wp_r + lzbd_pkg::pos_t'(1);
      wrapped_nxt   = wrapped_r || (wp_r == '1);
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_end_nxt   = step_end_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      count_r     <= '0;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      done_r      <= 1'b0;
      step_end_r  <= 1'b0;
      out_valid_r <= 1'b0;
      floor_r     <= lzbd_pkg::floor_t'(lzbd_pkg::FLOOR_RESET);
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      count_r     <= count_nxt;
      wp_r        <= wp_nxt;
      wrapped_r   <= wrapped_nxt;
      done_r      <= done_nxt;
      step_end_r  <= step_end_nxt;
      out_valid_r <= out_valid_nxt;
      // Saturate the floor on write
      if (cfg_valid && cfg_ready) begin
        floor_r <= (cfg_data > lzbd_pkg::floor_t'(lzbd_pkg::FLOOR_MAX)) ?
                   lzbd_pkg::floor_t'(lzbd_pkg::FLOOR_MAX) : cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    src_r       <= src_nxt;
    len_r       <= len_nxt;
    src_valid_r <= src_valid_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_end_r   <= out_end_nxt;
  end

`ifndef SYNTHESIS
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("end of stream flag cleared without reset");

  a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (count_r < lzbd_pkg::cnt_t'(lzbd_pkg::MATCH_TOK)))
    else $error("complete token left pending while idle");

  a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ || state_r == ST_COPY) |-> (len_r != '0))
    else $error("match copy running with zero length");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_valid_r && wp_r == $past(wp_r) + lzbd_pkg::pos_t'(1)))
    else $error("emitted byte not loaded or write pointer not advanced");
`endif

endmodule

// ===== rtl/lzbd_ram.sv =====
module lzbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
